### hw/rtl/lcct_pkg.sv
// Shared types and constants of the LRU chunk cache tag block.
`timescale 1ns / 1ps

package lcct_pkg;

   localparam int KEY_W  = 32;
   localparam int SLOT_W = 4;
   localparam int CNT_W  = 32;
   localparam int OCC_W  = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE,
      ST_COMMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;    // request channel ready
      logic scan;    // tag sweep step
      logic age;     // rank sweep step
      logic commit;  // apply the update and load the result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_valid;
      logic req_clear;
      logic sweep_done;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/lcct_if.sv
// Request and response channel interfaces of the LRU chunk cache tag block.
`timescale 1ns / 1ps

interface lcct_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [lcct_pkg::KEY_W-1:0] chunk_key;

   modport source (output valid, output operation, output chunk_key, input ready);
   modport sink   (input valid, input operation, input chunk_key, output ready);
endinterface

interface lcct_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic                        evicted;
   logic [lcct_pkg::KEY_W-1:0]  evicted_key;
   logic [lcct_pkg::SLOT_W-1:0] slot;
   logic [lcct_pkg::CNT_W-1:0]  hit_count;
   logic [lcct_pkg::CNT_W-1:0]  miss_count;
   logic [lcct_pkg::OCC_W-1:0]  occupancy;

   modport source (output valid, output hit, output evicted, output evicted_key,
                   output slot, output hit_count, output miss_count,
                   output occupancy, input ready);
   modport sink   (input valid, input hit, input evicted, input evicted_key,
                   input slot, input hit_count, input miss_count,
                   input occupancy, output ready);
endinterface

### hw/rtl/lcct_ctrl.sv
// Sequencer of the LRU chunk cache tag block: accept, tag sweep, rank sweep, commit (a clear skips the sweeps).
`timescale 1ns / 1ps

module lcct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  lcct_pkg::status_type status,
   output lcct_pkg::cmd_type    cmd
);

   lcct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         lcct_pkg::ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid) begin
               state_in = status.req_clear ? lcct_pkg::ST_COMMIT : lcct_pkg::ST_SCAN;
            end
         end
         lcct_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.sweep_done) begin
               state_in = lcct_pkg::ST_AGE;
            end
         end
         lcct_pkg::ST_AGE: begin
            cmd.age = 1'b1;
            if (status.sweep_done) begin
               state_in = lcct_pkg::ST_COMMIT;
            end
         end
         lcct_pkg::ST_COMMIT: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = lcct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcct_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/lcct_dpath.sv
// Datapath of the LRU chunk cache tag block: tag and rank memories, sweeps, counters.
`timescale 1ns / 1ps

module lcct_dpath #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcct_pkg::cmd_type    cmd,
   output lcct_pkg::status_type status,
   lcct_req_if.sink             req,
   lcct_rsp_if.source           rsp
);

   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW   = IDXW;
   localparam int LIMW = RW + 1;
   localparam int OCCW = $clog2(ENTRIES + 1);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
   localparam logic [RW-1:0]   OLDEST   = RW'(ENTRIES - 1);
   localparam logic [LIMW-1:0] LIM_ALL  = LIMW'(ENTRIES);
   localparam int CW = lcct_pkg::CNT_W;

   // storage
   logic [KEY_BITS-1:0] key_mem  [ENTRIES];
   logic [RW-1:0]       rank_mem [ENTRIES];
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [RW-1:0]       rank_rd_ff;

   // control state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDXW-1:0]    idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IDXW-1:0]    pidx_ff, pidx_in;
   logic [CW-1:0]      hits_ff, hits_in;
   logic [CW-1:0]      misses_ff, misses_in;
   logic [OCCW-1:0]    occ_ff, occ_in;
   logic               out_valid_ff, out_valid_in;

   // captured request and sweep results
   logic                op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                found_ff, found_in;
   logic [IDXW-1:0]     hit_slot_ff, hit_slot_in;
   logic [RW-1:0]       hit_rank_ff, hit_rank_in;
   logic                free_ff, free_in;
   logic [IDXW-1:0]     free_slot_ff, free_slot_in;
   logic [IDXW-1:0]     victim_slot_ff, victim_slot_in;
   logic [KEY_BITS-1:0] victim_key_ff, victim_key_in;

   // result word register
   logic                        out_hit_ff;
   logic                        out_evicted_ff;
   logic [lcct_pkg::KEY_W-1:0]  out_evkey_ff;
   logic [lcct_pkg::SLOT_W-1:0] out_slot_ff;
   logic [CW-1:0]               out_hits_ff;
   logic [CW-1:0]               out_misses_ff;
   logic [lcct_pkg::OCC_W-1:0]  out_occ_ff;

   logic                accept;
   logic                sweep;
   logic                last_seen;
   logic                rd_en;
   logic                ent_valid;
   logic [IDXW-1:0]     target;
   logic [LIMW-1:0]     limit;
   logic                age_wr;
   logic                commit_lookup;
   logic                commit_clear;
   logic                rank_we;
   logic [IDXW-1:0]     rank_waddr;
   logic [RW-1:0]       rank_wdata;
   logic                key_we;

   assign accept    = cmd.take && req.valid;
   assign sweep     = cmd.scan || cmd.age;
   assign last_seen = pend_ff && (pidx_ff == LAST_IDX);
   assign rd_en     = sweep && !last_seen;
   assign ent_valid = valid_ff[pidx_ff];

   assign commit_lookup = cmd.commit && (op_ff == lcct_pkg::OP_LOOKUP);
   assign commit_clear  = cmd.commit && (op_ff == lcct_pkg::OP_CLEAR);

   // hit slot, else lowest free slot, else the oldest entry
   assign target = found_ff ? hit_slot_ff : (free_ff ? free_slot_ff : victim_slot_ff);
   assign limit  = found_ff ? {1'b0, hit_rank_ff} : (free_ff ? LIM_ALL : {1'b0, OLDEST});

   assign age_wr = cmd.age && pend_ff && ent_valid && ({1'b0, rank_rd_ff} < limit);

   assign rank_we    = age_wr || commit_lookup;
   assign rank_waddr = age_wr ? pidx_ff : target;
   assign rank_wdata = age_wr ? RW'(rank_rd_ff + 1'b1) : '0;
   assign key_we     = commit_lookup && !found_ff;

   assign req.ready = cmd.take;

   assign status.req_valid  = req.valid;
   assign status.req_clear  = (req.operation == lcct_pkg::OP_CLEAR);
   assign status.sweep_done = last_seen;
   assign status.out_free   = !out_valid_ff || rsp.ready;

   // memories: one read and one write port each, registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff  <= key_mem[idx_ff];
         rank_rd_ff <= rank_mem[idx_ff];
      end
      if (key_we) begin
         key_mem[target] <= key_ff;
      end
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      pend_in = 1'b0;
      pidx_in = pidx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (sweep) begin
         idx_in  = last_seen ? '0 : IDXW'(idx_ff + 1'b1);
         pend_in = !last_seen;
         pidx_in = idx_ff;
      end
   end

   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      found_in       = found_ff;
      hit_slot_in    = hit_slot_ff;
      hit_rank_in    = hit_rank_ff;
      free_in        = free_ff;
      free_slot_in   = free_slot_ff;
      victim_slot_in = victim_slot_ff;
      victim_key_in  = victim_key_ff;
      if (accept) begin
         op_in    = req.operation;
         key_in   = KEY_BITS'(req.chunk_key);
         found_in = 1'b0;
         free_in  = 1'b0;
      end else if (cmd.scan && pend_ff) begin
         if (ent_valid && !found_ff && (key_rd_ff == key_ff)) begin
            found_in    = 1'b1;
            hit_slot_in = pidx_ff;
            hit_rank_in = rank_rd_ff;
         end
         if (!ent_valid && !free_ff) begin
            free_in      = 1'b1;
            free_slot_in = pidx_ff;
         end
         if (ent_valid && (rank_rd_ff == OLDEST)) begin
            victim_slot_in = pidx_ff;
            victim_key_in  = key_rd_ff;
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      occ_in    = occ_ff;
      if (commit_clear) begin
         valid_in = '0;
         occ_in   = '0;
      end else if (commit_lookup) begin
         valid_in[target] = 1'b1;
         if (found_ff) begin
            if (hits_ff != lcct_pkg::CNT_MAX) begin
               hits_in = hits_ff + 1'b1;
            end
         end else begin
            if (misses_ff != lcct_pkg::CNT_MAX) begin
               misses_in = misses_ff + 1'b1;
            end
            if (free_ff) begin
               occ_in = OCCW'(occ_ff + 1'b1);
            end
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      found_ff       <= found_in;
      hit_slot_ff    <= hit_slot_in;
      hit_rank_ff    <= hit_rank_in;
      free_ff        <= free_in;
      free_slot_ff   <= free_slot_in;
      victim_slot_ff <= victim_slot_in;
      victim_key_ff  <= victim_key_in;
      if (cmd.commit) begin
         out_hit_ff     <= commit_lookup && found_ff;
         out_evicted_ff <= commit_lookup && !found_ff && !free_ff;
         out_evkey_ff   <= (commit_lookup && !found_ff && !free_ff)
                           ? lcct_pkg::KEY_W'(victim_key_ff) : '0;
         out_slot_ff    <= commit_lookup ? lcct_pkg::SLOT_W'(target) : '0;
         out_hits_ff    <= hits_in;
         out_misses_ff  <= misses_in;
         out_occ_ff     <= lcct_pkg::OCC_W'(occ_in);
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.hit         = out_hit_ff;
   assign rsp.evicted     = out_evicted_ff;
   assign rsp.evicted_key = out_evkey_ff;
   assign rsp.slot        = out_slot_ff;
   assign rsp.hit_count   = out_hits_ff;
   assign rsp.miss_count  = out_misses_ff;
   assign rsp.occupancy   = out_occ_ff;

endmodule

### hw/rtl/lru_chunk_cache_tags_core.sv
// Top level of the LRU chunk cache tag block.
`timescale 1ns / 1ps

// Fully associative tag store with least-recently-used replacement over ENTRIES
// slots of KEY_BITS-bit chunk keys (the request key is cut or zero-extended to
// KEY_BITS). A lookup word passes an accept step, a tag sweep, a rank sweep and a
// commit step before the next word is accepted; the result word appears the
// cycle after commit. A clear word goes from its accept step straight to commit.
// Both sweeps are paced by the single read port of the key and rank memories,
// one entry per cycle. The result sits in an output register, so a new request
// is taken while the previous result waits; commit stalls only if that register
// is still full. Slot keys are undefined until written and need no clearing;
// valid bits reset at once, so no clearing pass is needed. Counters saturate at
// all ones and survive a clear.

module lru_chunk_cache_tags_core #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   lcct_req_if.sink   req_chan,
   lcct_rsp_if.source rsp_chan
);

   lcct_pkg::cmd_type    cmd;
   lcct_pkg::status_type status;

   // sequencer: idle -> tag sweep -> rank sweep -> commit; a clear goes idle -> commit
   lcct_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // tag and rank memories, valid bits, counters, result word register
   lcct_dpath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req_chan),
      .rsp    (rsp_chan)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for the LRU chunk cache tag block.
`timescale 1ns / 1ps

module testbench;

   localparam int ENTRIES = 16;
   localparam int RANDOM_WORDS = 1700;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 24;   // lookup turnaround plus margin
   localparam int IDLE_PCT = 35;
   localparam int HOLD_AT_RESULT = 400;              // where the long response stall starts
   localparam int HOLD_CYCLES = 300;                 // length of the response stall: fills the block
   localparam int CALM_FIRST = 900;                  // window with no idling on either side
   localparam int CALM_LAST = 1150;

   typedef struct packed {
      lcct_pkg::op_type                 op;
      logic [lcct_pkg::KEY_W-1:0]       key;
   } cache_req_type;

   typedef struct packed {
      logic                             hit;
      logic                             evicted;
      logic [lcct_pkg::KEY_W-1:0]       evicted_key;
      logic [lcct_pkg::SLOT_W-1:0]      slot;
      logic [lcct_pkg::CNT_W-1:0]       hit_count;
      logic [lcct_pkg::CNT_W-1:0]       miss_count;
      logic [lcct_pkg::OCC_W-1:0]       occupancy;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcct_req_if req_chan ();
   lcct_rsp_if rsp_chan ();

   lru_chunk_cache_tags_core #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (lcct_pkg::KEY_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Shadow copy of the tag store: keys, valid bits, recency ranks (0 = newest).
   logic [lcct_pkg::KEY_W-1:0]  tag_key   [ENTRIES];
   logic                        tag_valid [ENTRIES];
   logic [lcct_pkg::SLOT_W-1:0] tag_rank  [ENTRIES];
   logic [lcct_pkg::CNT_W-1:0]  hits_seen;
   logic [lcct_pkg::CNT_W-1:0]  misses_seen;

   cache_req_type    word_queue [$];     // words waiting to be offered
   cache_result_type outcomes_due [$];   // predicted responses, oldest first

   int words_taken = 0;
   int words_checked = 0;
   int mismatches = 0;
   int hold_left = 0;

   // Every valid slot newer than the limit rank ages by one.
   function automatic void age_newer(input int limit);
      for (int i = 0; i < ENTRIES; i++)
         if (tag_valid[i] && int'(tag_rank[i]) < limit)
            tag_rank[i] = tag_rank[i] + 1'b1;
   endfunction

   // Applies one request word to the shadow store and returns the response it yields.
   function automatic cache_result_type cache_outcome(
      input lcct_pkg::op_type op, input logic [lcct_pkg::KEY_W-1:0] key);
      cache_result_type r;
      int               found;
      int               free_slot;
      int               victim;
      int               target;
      int               occ;
      r = '0;
      found = -1;
      free_slot = -1;
      occ = 0;
      if (op == lcct_pkg::OP_CLEAR) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_rank[i] = '0;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tag_valid[i]) begin
               if (found < 0 && tag_key[i] == key)
                  found = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (found >= 0) begin
            r.hit = 1'b1;
            if (hits_seen != lcct_pkg::CNT_MAX)
               hits_seen = hits_seen + 1'b1;
            age_newer(int'(tag_rank[found]));
            tag_rank[found] = '0;
            target = found;
         end else begin
            if (misses_seen != lcct_pkg::CNT_MAX)
               misses_seen = misses_seen + 1'b1;
            if (free_slot >= 0) begin
               target = free_slot;
               age_newer(1 << lcct_pkg::SLOT_W);
            end else begin
               // full: the oldest slot carries the highest rank, lowest index on a tie
               victim = 0;
               for (int i = 1; i < ENTRIES; i++)
                  if (tag_rank[i] > tag_rank[victim])
                     victim = i;
               target = victim;
               r.evicted = 1'b1;
               r.evicted_key = tag_key[victim];
               age_newer(int'(tag_rank[victim]));
            end
            tag_key[target] = key;
            tag_valid[target] = 1'b1;
            tag_rank[target] = '0;
         end
         r.slot = target[lcct_pkg::SLOT_W-1:0];
      end
      for (int i = 0; i < ENTRIES; i++)
         if (tag_valid[i])
            occ++;
      r.hit_count = hits_seen;
      r.miss_count = misses_seen;
      r.occupancy = occ[lcct_pkg::OCC_W-1:0];
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [lcct_pkg::CNT_W-1:0] want,
                                input logic [lcct_pkg::CNT_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Appends one request word to the tail of the pending queue.
   task automatic queue_word(input lcct_pkg::op_type op,
                             input logic [lcct_pkg::KEY_W-1:0] key);
      cache_req_type w;
      w.op = op;
      w.key = key;
      word_queue = {word_queue, w};
   endtask

   // Random workload: phases over a working set of random keys, sized around the
   // cache capacity so hits, fills and evictions all occur; a few clears and
   // stray keys are mixed in as noise.
   task automatic queue_workload(input int count);
      logic [lcct_pkg::KEY_W-1:0] pool [$];
      int                         set_size;
      int                         run_len;
      int                         pick;
      int                         pushed;
      bit                         in_order;
      pushed = 0;
      while (pushed < count) begin
         case ($urandom_range(0, 6))
            0:       set_size = 3;
            1:       set_size = 8;
            2:       set_size = 15;
            3:       set_size = 16;
            4:       set_size = 17;
            5:       set_size = 24;
            default: set_size = 40;
         endcase
         pool.delete();
         for (int i = 0; i < set_size; i++)
            pool = {pool, lcct_pkg::KEY_W'($urandom())};
         in_order = 1'($urandom_range(0, 1));
         run_len = $urandom_range(40, 120);
         for (int n = 0; n < run_len && pushed < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
               queue_word(lcct_pkg::OP_CLEAR, $urandom());
            else if (pick < 9)
               queue_word(lcct_pkg::OP_LOOKUP, $urandom());
            else if (in_order)
               queue_word(lcct_pkg::OP_LOOKUP, pool[n % set_size]);
            else
               queue_word(lcct_pkg::OP_LOOKUP, pool[$urandom_range(0, set_size - 1)]);
            pushed++;
         end
      end
   endtask

   // Sampled at the falling edge so every update of the rising edge has landed.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (word_queue.size() != 0 || req_chan.valid || outcomes_due.size() != 0);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = lcct_pkg::OP_LOOKUP;
      req_chan.chunk_key = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         tag_key[i] = '0;
         tag_valid[i] = 1'b0;
         tag_rank[i] = '0;
      end
      hits_seen = '0;
      misses_seen = '0;
   end

   // Request driver: a word stays offered until taken; otherwise idle at random.
   always @(posedge clock) begin
      cache_req_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.operation <= lcct_pkg::OP_LOOKUP;
         req_chan.chunk_key <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            outcomes_due = {outcomes_due,
                            cache_outcome(lcct_pkg::op_type'(req_chan.operation),
                                          req_chan.chunk_key)};
            words_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (word_queue.size() != 0 &&
                ((words_taken >= CALM_FIRST && words_taken < CALM_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               w = word_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.operation <= w.op;
               req_chan.chunk_key <= w.key;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each taken word against the oldest prediction.
   always @(posedge clock) begin
      cache_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (outcomes_due.size() == 0) begin
               $error("response word with no request outstanding");
               mismatches++;
            end else begin
               want = outcomes_due.pop_front();
               compare_field("hit", lcct_pkg::CNT_W'(want.hit),
                             lcct_pkg::CNT_W'(rsp_chan.hit));
               compare_field("evicted", lcct_pkg::CNT_W'(want.evicted),
                             lcct_pkg::CNT_W'(rsp_chan.evicted));
               compare_field("evicted_key", want.evicted_key, rsp_chan.evicted_key);
               compare_field("slot", lcct_pkg::CNT_W'(want.slot),
                             lcct_pkg::CNT_W'(rsp_chan.slot));
               compare_field("hit_count", want.hit_count, rsp_chan.hit_count);
               compare_field("miss_count", want.miss_count, rsp_chan.miss_count);
               compare_field("occupancy", lcct_pkg::CNT_W'(want.occupancy),
                             lcct_pkg::CNT_W'(rsp_chan.occupancy));
            end
            words_checked++;
            // long stall: the result register fills, commit blocks, request side backs up
            if (words_checked == HOLD_AT_RESULT)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (words_checked >= CALM_FIRST && words_checked < CALM_LAST) ||
                              $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear on empty, extreme keys, a hit, fill to full, eviction of
      // the oldest entry (including one whose key is zero), clear with data held.
      queue_word(lcct_pkg::OP_CLEAR, '1);
      queue_word(lcct_pkg::OP_LOOKUP, '0);
      queue_word(lcct_pkg::OP_LOOKUP, '1);
      queue_word(lcct_pkg::OP_LOOKUP, '0);
      for (int i = 0; i < ENTRIES - 2; i++)
         queue_word(lcct_pkg::OP_LOOKUP, lcct_pkg::KEY_W'(1) << i);
      queue_word(lcct_pkg::OP_LOOKUP, 32'h8000_0000);
      queue_word(lcct_pkg::OP_LOOKUP, '1);
      queue_word(lcct_pkg::OP_LOOKUP, 32'h0000_0020);
      queue_word(lcct_pkg::OP_CLEAR, '0);
      queue_word(lcct_pkg::OP_LOOKUP, '1);
      queue_word(lcct_pkg::OP_CLEAR, 32'h5A5A_5A5A);
      wait_drained();

      // sender pauses between halves until every response is back
      queue_workload(RANDOM_WORDS / 2);
      wait_drained();
      queue_workload(RANDOM_WORDS - RANDOM_WORDS / 2);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outcomes_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/lcct_pkg.sv
hw/rtl/lcct_if.sv
hw/rtl/lcct_ctrl.sv
hw/rtl/lcct_dpath.sv
hw/rtl/lru_chunk_cache_tags_core.sv
tb/testbench.sv
